### hdl/ruc_pkg.sv
// shared types and constants of the rate unchoke selector
`default_nettype none
package ruc_pkg;

  localparam int SLOTS  = 4;
  localparam int PEER_W = 10;
  localparam int RATE_W = 32;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ACT_CHOKE   = 2'd0,
    ACT_UNCHOKE = 2'd1,
    ACT_EMPTY   = 2'd2
  } action_t;

  typedef struct packed {
    logic              full;
    logic [PEER_W-1:0] peer;
    logic [RATE_W-1:0] rate;
  } entry_t;

  typedef struct packed {
    logic step;
    logic shift;
  } cell_ctl_t;

  localparam entry_t ENTRY_EMPTY = '0;

endpackage
`default_nettype wire

### hdl/ruc_if.sv
// offer and result channel interfaces
`default_nettype none
interface ruc_offer_if;
  import ruc_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [PEER_W-1:0] peer_id;
  logic [RATE_W-1:0] upload_rate;
  logic              peer_ready;
  modport source (output valid, mode, peer_id, upload_rate, peer_ready, input ready);
  modport sink (input valid, mode, peer_id, upload_rate, peer_ready, output ready);
endinterface

interface ruc_result_if;
  import ruc_pkg::*;
  logic              valid;
  logic              ready;
  logic [PEER_W-1:0] out_peer;
  logic [1:0]        action;
  logic              last;
  modport source (output valid, out_peer, action, last, input ready);
  modport sink (input valid, out_peer, action, last, output ready);
endinterface
`default_nettype wire

### hdl/ruc_cell.sv
// one slot of the ranking chain with its carry register
`default_nettype none
module ruc_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ruc_pkg::cell_ctl_t ctl,
  input  wire ruc_pkg::entry_t    carry_in,
  input  wire ruc_pkg::entry_t    shift_in,
  output ruc_pkg::entry_t         carry_out,
  output ruc_pkg::entry_t         slot
);
  import ruc_pkg::*;

  logic swap;

  assign swap = carry_in.full && (!slot.full || (slot.rate <= carry_in.rate));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.full      <= 1'b0;
      carry_out.full <= 1'b0;
    end else if (ctl.shift) begin
      slot <= shift_in;
    end else if (ctl.step) begin
      if (swap) begin
        slot      <= carry_in;
        carry_out <= slot;
      end else begin
        carry_out <= carry_in;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/top_rate_unchoke_selector.sv
// top level: slot chain, round sequencer and result register
// Keeps the SLOTS fastest peers in a chain of slot cells ordered by upload
// rate. An offer is taken into an inject register and carried one cell per
// cycle down the chain, swapping into each empty or slower-or-equal slot; an
// offer occupies the block for its walk down the chain, plus any wait for the
// result register when a peer falls off the end and is reported as a choke. A
// finish shifts the chain toward slot 0 one slot per cycle while the result
// register is free, giving one unchoke or empty-slot result per slot, the
// last one flagged, and leaves the table empty.
// Offers with peer_ready low pass through the chain and change nothing.
`default_nettype none
module top_rate_unchoke_selector (
  input  wire logic   clk,
  input  wire logic   rst,
  ruc_offer_if.sink   offer,
  ruc_result_if.source result
);
  import ruc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  cell_ctl_t        ctl;
  entry_t           inject;
  entry_t           slot_q  [SLOTS];
  entry_t           carry_q [SLOTS];
  logic             accept;
  logic             out_free;
  logic             load;
  logic [PEER_W-1:0] load_peer;
  action_t          load_action;
  logic             load_last;

  assign offer.ready = (state == ST_IDLE);
  assign accept      = offer.valid && offer.ready;
  assign out_free    = !result.valid || result.ready;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t cin, sin;
    if (i == 0) begin : g_first
      assign cin = inject;
    end else begin : g_mid
      assign cin = carry_q[i-1];
    end
    if (i == SLOTS - 1) begin : g_end
      assign sin = ENTRY_EMPTY;
    end else begin : g_inner
      assign sin = slot_q[i+1];
    end
    ruc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .carry_in  (cin),
      .shift_in  (sin),
      .carry_out (carry_q[i]),
      .slot      (slot_q[i])
    );
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ctl         = '0;
    load        = 1'b0;
    load_peer   = '0;
    load_action = ACT_EMPTY;
    load_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next   = '0;
          state_next = offer.mode ? ST_DRAIN : ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (cnt != CNT_SLOTS) begin
          ctl.step = 1'b1;
          cnt_next = cnt + 1'b1;
        end else if (!carry_q[SLOTS-1].full) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          load        = 1'b1;
          load_peer   = carry_q[SLOTS-1].peer;
          load_action = ACT_CHOKE;
          load_last   = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load        = 1'b1;
          ctl.shift   = 1'b1;
          load_peer   = slot_q[0].full ? slot_q[0].peer : '0;
          load_action = slot_q[0].full ? ACT_UNCHOKE : ACT_EMPTY;
          load_last   = (cnt == CNT_LAST);
          if (cnt == CNT_LAST) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inject.full <= 1'b0;
    end else if (accept && !offer.mode) begin
      inject.full <= offer.peer_ready;
      inject.peer <= offer.peer_id;
      inject.rate <= offer.upload_rate;
    end else if (ctl.step) begin
      inject.full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid    <= 1'b1;
      result.out_peer <= load_peer;
      result.action   <= load_action;
      result.last     <= load_last;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  a_no_step_and_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.step && ctl.shift))
    else $error("chain stepped and shifted in one cycle");

  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    (accept && offer.mode) |=> (state == ST_DRAIN))
    else $error("finish item did not start a drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && load && load_last) |=> (state == ST_IDLE))
    else $error("drain continued after last result");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |-> (cnt <= CNT_SLOTS))
    else $error("insert walk ran past the chain");

endmodule
`default_nettype wire

### tb/testbench.sv
// self-checking testbench of the rate unchoke selector
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ruc_pkg::*;

  typedef struct {
    logic              mode;
    logic [PEER_W-1:0] peer;
    logic [RATE_W-1:0] rate;
    logic              ready;
  } offer_t;

  typedef struct {
    logic              mode;
    logic [PEER_W-1:0] peer;
    logic [RATE_W-1:0] rate;
    logic              ready;
    int                nres;
    logic [PEER_W-1:0] xpeer;
    action_t           xact;
  } plan_row_t;

  typedef struct packed {
    logic [PEER_W-1:0] peer;
    action_t           act;
    logic              last;
  } peer_action_t;

  localparam int NPLAN = 21;

  // nres -1: expectation from the ranking model; otherwise nres results of
  // xpeer/xact, the final one flagged last
  plan_row_t plan [NPLAN] = '{
    '{1'b1,    10'd0,            32'd0, 1'b0,  4,   10'd0, ACT_EMPTY},
    '{1'b0, 10'd1023,   32'hFFFF_FFFF, 1'b0,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd0,            32'd0, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0, 10'd1023,   32'hFFFF_FFFF, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd5,          32'd100, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd6,          32'd100, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd7,            32'd0, 1'b1,  1,   10'd0, ACT_CHOKE},
    '{1'b0,    10'd8,            32'd1, 1'b0,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd9,   32'hFFFF_FFFF, 1'b1, -1,   10'd0, ACT_EMPTY},
    '{1'b1, 10'd1023,   32'hFFFF_FFFF, 1'b1, -1,   10'd0, ACT_EMPTY},
    '{1'b1,    10'd0,            32'd0, 1'b0,  4,   10'd0, ACT_EMPTY},
    '{1'b0,  10'd512,   32'h8000_0000, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,  10'd511,   32'h7FFF_FFFF, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd3,            32'd1, 1'b0,  0,   10'd0, ACT_EMPTY},
    '{1'b1,    10'd5,            32'd5, 1'b0, -1,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd1,            32'd1, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd2,            32'd1, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd3,            32'd2, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,    10'd4,            32'd0, 1'b1,  0,   10'd0, ACT_EMPTY},
    '{1'b0,  10'd600,            32'd0, 1'b1, -1,   10'd0, ACT_EMPTY},
    '{1'b1,    10'd0,            32'd0, 1'b1, -1,   10'd0, ACT_EMPTY}
  };

  logic clk = 1'b0;
  logic rst;

  ruc_offer_if  offer ();
  ruc_result_if result ();

  top_rate_unchoke_selector dut (
    .clk    (clk),
    .rst    (rst),
    .offer  (offer),
    .result (result)
  );

  logic [PEER_W-1:0] rank_peer [SLOTS];
  logic [RATE_W-1:0] rank_rate [SLOTS];
  logic              rank_full [SLOTS];
  peer_action_t      due_actions [$];
  peer_action_t      seen;
  int                errors = 0;
  bit                no_idle = 1'b0;
  bit                hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic clear_ranking();
    for (int i = 0; i < SLOTS; i++) begin
      rank_peer[i] = '0;
      rank_rate[i] = '0;
      rank_full[i] = 1'b0;
    end
  endtask

  // walk an offer down the ranking, or read out and clear it on a finish
  task automatic rank_offer(input offer_t it);
    logic [PEER_W-1:0] cp, tp;
    logic [RATE_W-1:0] cr, tr;
    logic              cf, tf;
    if (it.mode) begin
      for (int i = 0; i < SLOTS; i++) begin
        due_actions.push_back('{peer: rank_full[i] ? rank_peer[i] : '0,
                                act: rank_full[i] ? ACT_UNCHOKE : ACT_EMPTY,
                                last: (i == SLOTS - 1)});
      end
      clear_ranking();
    end else if (it.ready) begin
      cp = it.peer;
      cr = it.rate;
      cf = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (cf && (!rank_full[i] || rank_rate[i] <= cr)) begin
          tp = rank_peer[i];
          tr = rank_rate[i];
          tf = rank_full[i];
          rank_peer[i] = cp;
          rank_rate[i] = cr;
          rank_full[i] = 1'b1;
          cp = tp;
          cr = tr;
          cf = tf;
        end
      end
      if (cf) begin
        due_actions.push_back('{peer: cp, act: ACT_CHOKE, last: 1'b1});
      end
    end
  endtask

  task automatic send_offer(input offer_t it, input int nres,
                            input logic [PEER_W-1:0] xpeer, input action_t xact);
    int n0;
    offer.valid       <= 1'b1;
    offer.mode        <= it.mode;
    offer.peer_id     <= it.peer;
    offer.upload_rate <= it.rate;
    offer.peer_ready  <= it.ready;
    @(posedge clk);
    while (!offer.ready) @(posedge clk);
    n0 = due_actions.size();
    rank_offer(it);
    if (nres >= 0) begin
      while (due_actions.size() > n0) void'(due_actions.pop_back());
      for (int k = 0; k < nres; k++) begin
        due_actions.push_back('{peer: xpeer, act: xact, last: (k == nres - 1)});
      end
    end
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      offer.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return RATE_W'($urandom_range(0, 7));
      1: return $urandom;
      2: return $urandom_range(0, 1) ? '1 : RATE_W'($urandom_range(0, 1));
      default: return RATE_W'($urandom_range(0, 1000));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    result.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      if (!no_idle) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (due_actions.size() == 0) begin
        report("unexpected result, out_peer", result.out_peer, 0);
      end else begin
        seen = due_actions.pop_front();
        if (result.out_peer !== seen.peer) report("out_peer", result.out_peer, seen.peer);
        if (result.action !== seen.act) report("action", result.action, seen.act);
        if (result.last !== seen.last) report("last", result.last, seen.last);
      end
    end
  end

  initial begin
    offer_t it;
    int     counted;
    int     len;
    bit     held;
    rst               <= 1'b1;
    offer.valid       <= 1'b0;
    offer.mode        <= 1'b0;
    offer.peer_id     <= '0;
    offer.upload_rate <= '0;
    offer.peer_ready  <= 1'b0;
    clear_ranking();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NPLAN; r++) begin
      it = '{plan[r].mode, plan[r].peer, plan[r].rate, plan[r].ready};
      send_offer(it, plan[r].nres, plan[r].xpeer, plan[r].xact);
    end

    // rounds of offers closed by a finish
    counted = 0;
    held = 1'b0;
    while (counted < 230) begin
      len = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        it.mode  = 1'b0;
        it.peer  = PEER_W'($urandom_range(0, 1023));
        it.rate  = pick_rate();
        it.ready = ($urandom_range(0, 7) != 0);
        counted++;
        send_offer(it, -1, '0, ACT_EMPTY);
      end
      it.mode  = 1'b1;
      it.peer  = PEER_W'($urandom_range(0, 1023));
      it.rate  = $urandom;
      it.ready = 1'($urandom_range(0, 1));
      counted++;
      send_offer(it, -1, '0, ACT_EMPTY);
      if (!held && counted >= 40) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (counted > 200) no_idle = 1'b1;
    end

    offer.valid <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk);
    repeat (4 * SLOTS + 10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
